FILE: hdl/pcsr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the particle circle span rasterizer.
// Used by pcsr_mac and particle_circle_span_raster_unit; depends on nothing.

package pcsr_pkg;

    // Largest pixel radius; the radius register width follows from it
    localparam int MAX_RADIUS = 31;
    localparam int R_W        = $clog2(MAX_RADIUS + 1);
    localparam int DY_W       = R_W + 1;
    localparam int BIT_W      = (R_W > 1) ? $clog2(R_W) : 1;

    // Configuration register indexes
    localparam logic [1:0] CFG_PPM    = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    // Reset values of the configuration registers
    localparam logic [15:0] PPM_RESET    = 16'd100;
    localparam logic [12:0] WIDTH_RESET  = 13'd800;
    localparam logic [12:0] HEIGHT_RESET = 13'd600;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AXIS,
        ST_RADIUS,
        ST_RSAT,
        ST_ROOT,
        ST_EMIT
    } state_t;

    // Accumulator operations of the shared multiply-accumulate unit
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD_PROD,
        ACC_ADD_PROD_HI,
        ACC_ADD_ROUND
    } acc_op_t;

    // Control word from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic               mul_en;
        logic signed [32:0] mul_a;
        logic signed [17:0] mul_b;
        acc_op_t            acc_op;
        logic signed [63:0] load_val;
    } mac_ctrl_t;

endpackage

FILE: hdl/particle_circle_span_raster_unit.sv
`timescale 1ns / 1ps
// Top level of the particle circle span rasterizer: sequencer, operand
// registers, row square root and output register. Uses pcsr_pkg, pcsr_mac.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------
//  s_axis   | in        | s_axis_tvalid/tready   | tdata: one particle
//  m_axis   | out       | m_axis_tvalid/tready   | tdata: one span, tlast: last row
//  cfg      | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// A particle of pixel radius r yields 2r + 1 spans, one per row. The two
// screen coordinates and the pixel radius go through the one shared
// multiply-accumulate unit (eight steps per coordinate, two for the radius);
// each row then goes through a bit-serial square root and a load of the
// output register. s_axis_tready is high only in idle; a span waiting in
// the output register does not block the next particle. A stall on m_axis
// holds the sequencer in its emit step. Reset is asynchronous, active low,
// and restores the configuration defaults.

module particle_circle_span_raster_unit
(
    input  logic          clk,
    input  logic          rst_n,

    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // prev_x[31:0], prev_y[63:32], cur_x[95:64], cur_y[127:96],
    // radius_m[158:128], alpha[175:159], color[207:176]
    input  logic [207:0]  s_axis_tdata,

    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // row_y[15:0], span_left[31:16], span_right[47:32], span_color[79:48]
    output logic [79:0]   m_axis_tdata,
    // last_row
    output logic          m_axis_tlast,

    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data
);

    localparam int R_W   = pcsr_pkg::R_W;
    localparam int DY_W  = pcsr_pkg::DY_W;
    localparam int BIT_W = pcsr_pkg::BIT_W;

    // Configuration registers
    logic [15:0] ppm_reg, ppm_next;
    logic [12:0] width_reg, width_next;
    logic [12:0] height_reg, height_next;

    // Control registers
    pcsr_pkg::state_t state_reg, state_next;
    logic             axis_reg, axis_next;
    logic [2:0]       phase_reg, phase_next;
    logic             out_valid_reg, out_valid_next;

    // Particle operands
    logic signed [31:0] px_reg, px_next, py_reg, py_next;
    logic signed [31:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [30:0]        rad_reg, rad_next;
    logic [16:0]        alpha_reg, alpha_next;
    logic [31:0]        color_reg, color_next;

    // Working registers
    logic signed [32:0] diff_reg, diff_next;
    logic signed [15:0] ihi_reg, ihi_next;
    logic signed [31:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [R_W-1:0]     r_reg, r_next;
    logic signed [DY_W-1:0] dy_reg, dy_next;
    logic [R_W-1:0]     w_reg, w_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;

    // Output registers
    logic [15:0] row_reg, row_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] right_reg, right_next;
    logic [31:0] ocolor_reg, ocolor_next;
    logic        last_reg, last_next;

    // Shared unit
    pcsr_pkg::mac_ctrl_t mac_ctrl;
    logic signed [50:0]  mac_prod;
    logic signed [63:0]  mac_acc;

    // Helpers
    logic signed [31:0] p_sel, c_sel;
    logic [11:0]        half_sel;
    logic [R_W-1:0]     trial;
    logic [R_W-1:0]     dy_abs;
    logic [2*R_W-1:0]   rsq, trial_sq, dy_sq;
    logic [2*R_W:0]     fit_sum;
    logic               row_last;
    logic               out_load;
    logic [R_W-1:0]     r_sat;
    logic [BIT_W-1:0]   bit_top;

    pcsr_mac u_mac
    (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .prod (mac_prod),
        .acc  (mac_acc)
    );

    function automatic logic [15:0] sat16(input logic signed [32:0] v);
        logic [15:0] res;
        if (v > 33'sd32767)
        begin
            res = 16'h7FFF;
        end
        else if (v < -33'sd32768)
        begin
            res = 16'h8000;
        end
        else
        begin
            res = v[15:0];
        end
        return res;
    endfunction

    // Select the axis under work
    assign p_sel    = axis_reg ? py_reg : px_reg;
    assign c_sel    = axis_reg ? cy_reg : cx_reg;
    assign half_sel = axis_reg ? height_reg[12:1] : width_reg[12:1];

    // Row square root step: keep the trial bit if trial^2 + dy^2 <= r^2
    assign bit_top  = BIT_W'(R_W - 1);
    assign trial    = w_reg | (R_W'(1) << bit_reg);
    assign dy_abs   = dy_reg[DY_W-1] ? R_W'(-dy_reg) : dy_reg[R_W-1:0];
    assign rsq      = r_reg * r_reg;
    assign trial_sq = trial * trial;
    assign dy_sq    = dy_abs * dy_abs;
    assign fit_sum  = {1'b0, trial_sq} + {1'b0, dy_sq};
    assign row_last = (dy_reg == $signed({1'b0, r_reg}));

    // Saturate the pixel radius from the scaled product
    assign r_sat = (mac_prod[46:16] > 31'(pcsr_pkg::MAX_RADIUS))
                   ? R_W'(pcsr_pkg::MAX_RADIUS) : mac_prod[16 +: R_W];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pcsr_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = pcsr_pkg::ST_AXIS;
                end
            end
            pcsr_pkg::ST_AXIS:
            begin
                if (phase_reg == 3'd7 && axis_reg)
                begin
                    state_next = pcsr_pkg::ST_RADIUS;
                end
            end
            pcsr_pkg::ST_RADIUS:
            begin
                state_next = pcsr_pkg::ST_RSAT;
            end
            pcsr_pkg::ST_RSAT:
            begin
                state_next = pcsr_pkg::ST_ROOT;
            end
            pcsr_pkg::ST_ROOT:
            begin
                if (bit_reg == '0)
                begin
                    state_next = pcsr_pkg::ST_EMIT;
                end
            end
            pcsr_pkg::ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = row_last ? pcsr_pkg::ST_IDLE : pcsr_pkg::ST_ROOT;
                end
            end
            default:
            begin
                state_next = pcsr_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: handshakes and the shared unit's control word
    always_comb
    begin
        s_axis_tready    = (state_reg == pcsr_pkg::ST_IDLE);
        out_load         = (state_reg == pcsr_pkg::ST_EMIT)
                           && (!out_valid_reg || m_axis_tready);
        mac_ctrl.mul_en   = 1'b0;
        mac_ctrl.mul_a    = '0;
        mac_ctrl.mul_b    = '0;
        mac_ctrl.acc_op   = pcsr_pkg::ACC_HOLD;
        mac_ctrl.load_val = '0;
        case (state_reg)
            pcsr_pkg::ST_AXIS:
            begin
                case (phase_reg)
                    // Start from prev scaled to Q.32
                    3'd0:
                    begin
                        mac_ctrl.acc_op   = pcsr_pkg::ACC_LOAD;
                        mac_ctrl.load_val = {{16{p_sel[31]}}, p_sel, 16'b0};
                    end
                    // (cur - prev) * alpha
                    3'd1:
                    begin
                        mac_ctrl.mul_en = 1'b1;
                        mac_ctrl.mul_a  = diff_reg;
                        mac_ctrl.mul_b  = {1'b0, alpha_reg};
                    end
                    3'd2:
                    begin
                        mac_ctrl.acc_op = pcsr_pkg::ACC_ADD_PROD;
                    end
                    // Low word times scale; restart from the centre
                    3'd3:
                    begin
                        mac_ctrl.mul_en   = 1'b1;
                        mac_ctrl.mul_a    = {1'b0, mac_acc[31:0]};
                        mac_ctrl.mul_b    = {2'b0, ppm_reg};
                        mac_ctrl.acc_op   = pcsr_pkg::ACC_LOAD;
                        mac_ctrl.load_val = {20'b0, half_sel, 32'b0};
                    end
                    // High word times scale
                    3'd4:
                    begin
                        mac_ctrl.mul_en = 1'b1;
                        mac_ctrl.mul_a  = {{17{ihi_reg[15]}}, ihi_reg};
                        mac_ctrl.mul_b  = {2'b0, ppm_reg};
                        mac_ctrl.acc_op = pcsr_pkg::ACC_ADD_PROD;
                    end
                    3'd5:
                    begin
                        mac_ctrl.acc_op = pcsr_pkg::ACC_ADD_PROD_HI;
                    end
                    3'd6:
                    begin
                        mac_ctrl.acc_op = pcsr_pkg::ACC_ADD_ROUND;
                    end
                    default:
                    begin
                        mac_ctrl.acc_op = pcsr_pkg::ACC_HOLD;
                    end
                endcase
            end
            pcsr_pkg::ST_RADIUS:
            begin
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.mul_a  = {2'b0, rad_reg};
                mac_ctrl.mul_b  = {2'b0, ppm_reg};
            end
            default:
            begin
                mac_ctrl.mul_en = 1'b0;
            end
        endcase
    end

    // Configuration writes; unknown indexes drop
    always_comb
    begin
        ppm_next    = ppm_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                pcsr_pkg::CFG_PPM:    ppm_next    = cfg_data;
                pcsr_pkg::CFG_WIDTH:  width_next  = cfg_data[12:0];
                pcsr_pkg::CFG_HEIGHT: height_next = cfg_data[12:0];
                default:              ppm_next    = ppm_reg;
            endcase
        end
    end

    // Datapath registers
    always_comb
    begin
        axis_next  = axis_reg;
        phase_next = phase_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        rad_next   = rad_reg;
        alpha_next = alpha_reg;
        color_next = color_reg;
        diff_next  = diff_reg;
        ihi_next   = ihi_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        r_next     = r_reg;
        dy_next    = dy_reg;
        w_next     = w_reg;
        bit_next   = bit_reg;
        case (state_reg)
            // Capture the particle, saturating alpha at one
            pcsr_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    px_next    = s_axis_tdata[31:0];
                    py_next    = s_axis_tdata[63:32];
                    cx_next    = s_axis_tdata[95:64];
                    cy_next    = s_axis_tdata[127:96];
                    rad_next   = s_axis_tdata[158:128];
                    alpha_next = s_axis_tdata[175] ? 17'h10000 : s_axis_tdata[175:159];
                    color_next = s_axis_tdata[207:176];
                    axis_next  = 1'b0;
                    phase_next = 3'd0;
                end
            end
            pcsr_pkg::ST_AXIS:
            begin
                phase_next = phase_reg + 3'd1;
                if (phase_reg == 3'd0)
                begin
                    diff_next = {c_sel[31], c_sel} - {p_sel[31], p_sel};
                end
                if (phase_reg == 3'd3)
                begin
                    ihi_next = mac_acc[47:32];
                end
                // Take the rounded coordinate and move to the next axis
                if (phase_reg == 3'd7)
                begin
                    if (axis_reg)
                    begin
                        sy_next = mac_acc[63:32];
                    end
                    else
                    begin
                        sx_next = mac_acc[63:32];
                    end
                    axis_next = 1'b1;
                end
            end
            // Start at the top row
            pcsr_pkg::ST_RSAT:
            begin
                r_next   = r_sat;
                dy_next  = -$signed({1'b0, r_sat});
                w_next   = '0;
                bit_next = bit_top;
            end
            pcsr_pkg::ST_ROOT:
            begin
                if (fit_sum <= {1'b0, rsq})
                begin
                    w_next = trial;
                end
                if (bit_reg != '0)
                begin
                    bit_next = bit_reg - BIT_W'(1);
                end
            end
            // Advance to the next row once the span is loaded
            pcsr_pkg::ST_EMIT:
            begin
                if (out_load && !row_last)
                begin
                    dy_next  = dy_reg + DY_W'(1);
                    w_next   = '0;
                    bit_next = bit_top;
                end
            end
            default:
            begin
                w_next = w_reg;
            end
        endcase
    end

    // Output register: load a span, drop it once taken
    always_comb
    begin
        row_next       = row_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        ocolor_next    = ocolor_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            row_next       = sat16({sy_reg[31], sy_reg} + {{(33-DY_W){dy_reg[DY_W-1]}}, dy_reg});
            left_next      = sat16({sx_reg[31], sx_reg} - {{(33-R_W){1'b0}}, w_reg});
            right_next     = sat16({sx_reg[31], sx_reg} + {{(33-R_W){1'b0}}, w_reg});
            ocolor_next    = color_reg;
            last_next      = row_last;
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and configuration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcsr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            ppm_reg       <= pcsr_pkg::PPM_RESET;
            width_reg     <= pcsr_pkg::WIDTH_RESET;
            height_reg    <= pcsr_pkg::HEIGHT_RESET;
            axis_reg      <= 1'b0;
            phase_reg     <= 3'd0;
            bit_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            ppm_reg       <= ppm_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            axis_reg      <= axis_next;
            phase_reg     <= phase_next;
            bit_reg       <= bit_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        px_reg     <= px_next;
        py_reg     <= py_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        rad_reg    <= rad_next;
        alpha_reg  <= alpha_next;
        color_reg  <= color_next;
        diff_reg   <= diff_next;
        ihi_reg    <= ihi_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        r_reg      <= r_next;
        dy_reg     <= dy_next;
        w_reg      <= w_next;
        row_reg    <= row_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        ocolor_reg <= ocolor_next;
        last_reg   <= last_next;
    end

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {ocolor_reg, right_reg, left_reg, row_reg};
    assign m_axis_tlast  = last_reg;

endmodule

FILE: hdl/pcsr_mac.sv
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: one 33x18 signed multiplier with a
// registered product and one 64-bit accumulator adder. Uses pcsr_pkg.

module pcsr_mac
(
    input  logic                    clk,
    input  pcsr_pkg::mac_ctrl_t     ctrl,
    output logic signed [50:0]      prod,
    output logic signed [63:0]      acc
);

    logic signed [50:0] prod_reg;
    logic signed [50:0] prod_next;
    logic signed [63:0] acc_reg;
    logic signed [63:0] acc_next;
    logic signed [63:0] addend;

    // Multiply when asked, otherwise hold the product
    always_comb
    begin
        prod_next = prod_reg;
        if (ctrl.mul_en)
        begin
            prod_next = ctrl.mul_a * ctrl.mul_b;
        end
    end

    // Select the addend for the shared adder
    always_comb
    begin
        case (ctrl.acc_op)
            pcsr_pkg::ACC_ADD_PROD:    addend = {{13{prod_reg[50]}}, prod_reg};
            pcsr_pkg::ACC_ADD_PROD_HI: addend = {prod_reg[31:0], 32'b0};
            // Half away from zero: negative values take one less
            pcsr_pkg::ACC_ADD_ROUND:   addend = acc_reg[63] ? 64'sh7FFF_FFFF
                                                            : 64'sh8000_0000;
            default:                   addend = '0;
        endcase
    end

    // Load, add or hold the accumulator
    always_comb
    begin
        case (ctrl.acc_op)
            pcsr_pkg::ACC_LOAD:        acc_next = ctrl.load_val;
            pcsr_pkg::ACC_ADD_PROD,
            pcsr_pkg::ACC_ADD_PROD_HI,
            pcsr_pkg::ACC_ADD_ROUND:   acc_next = acc_reg + addend;
            default:                   acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule
